@@ rtl/ball_search_and_track_head_control_top_defines.svh @@
// Assertion macros for the ball search and track head control checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef BALL_SEARCH_AND_TRACK_HEAD_CONTROL_TOP_DEFINES_SVH
`define BALL_SEARCH_AND_TRACK_HEAD_CONTROL_TOP_DEFINES_SVH

// property checked at every clock edge out of reset
`define BSTHC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bsthc: assertion failed");

// implication from a condition to the next cycle
`define BSTHC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsthc: assertion failed");

`endif

@@ rtl/bsthc_pkg.sv @@
// Shared types, constants and helper functions for the ball search and
// track head control block. No dependencies.
package bsthc_pkg;

	localparam int IMG_WIDTH  = 320;
	localparam int IMG_HEIGHT = 240;

	localparam logic signed [11:0] CENTER_X        = 12'(IMG_WIDTH / 2);
	localparam logic signed [11:0] CENTER_Y_SEARCH = 12'(IMG_HEIGHT / 2);
	localparam logic signed [11:0] CENTER_Y_TRACK  = 12'(IMG_HEIGHT / 3);

	localparam logic signed [15:0] PAN_STEP    = 16'sd32;
	localparam logic signed [15:0] TILT_STEP   = 16'sd16;
	localparam logic signed [15:0] LOST_OFFSET = -16'sd16;
	localparam logic signed [28:0] ROUND_HALF  = 29'sd128;

	localparam int IN_W       = 48;
	localparam int OUT_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register reset values and the counter ceiling
	localparam logic        RST_TRACK_ONLY  = 1'b0;
	localparam logic [11:0] RST_PAN_LIMIT   = 12'd1120;
	localparam logic [11:0] RST_TILT_TOP    = 12'd160;
	localparam logic [11:0] RST_TILT_BOTTOM = 12'hE20;
	localparam logic [7:0]  RST_PATIENCE    = 8'd15;
	localparam logic [7:0]  RST_GIVE_UP     = 8'd20;
	localparam logic [15:0] RST_H_GAIN      = 16'd742;
	localparam logic [15:0] RST_V_GAIN      = 16'd821;
	localparam logic [7:0]  COUNT_MAX       = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRACK_ONLY,
		REG_PAN_LIMIT,
		REG_TILT_TOP,
		REG_TILT_BOTTOM,
		REG_PATIENCE,
		REG_GIVE_UP,
		REG_H_GAIN,
		REG_V_GAIN
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_TRACK,
		ACT_SCAN,
		ACT_INIT
	} action_t;

	typedef enum logic [1:0] {
		ST_LOST,
		ST_GIVEN_UP,
		ST_FOUND
	} status_t;

	typedef enum logic [1:0] {
		PH_SWEEP_UP,
		PH_SWEEP_DOWN,
		PH_SWEEP_TILT
	} phase_t;

	typedef struct packed {
		logic [11:0]        pan_limit;
		logic signed [11:0] tilt_top;
		logic signed [11:0] tilt_bottom;
	} scan_cfg_t;

	typedef struct packed {
		logic signed [12:0] target_pan;
		logic signed [12:0] target_tilt;
		phase_t             next_phase;
	} scan_res_t;

	function automatic logic signed [12:0] sat13(input logic signed [15:0] v);
		logic signed [12:0] r;
		if (v > 16'sd4095)
			r = 13'sd4095;
		else if (v < -16'sd4096)
			r = -13'sd4096;
		else
			r = v[12:0];
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		logic signed [15:0] r;
		if (v > 21'sd32767)
			r = 16'sh7FFF;
		else if (v < -21'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

@@ rtl/bsthc_offset.sv @@
// Angular offset of one ball coordinate from the image center:
// -(pos - center) * gain / 256, round half up, saturated. Uses bsthc_pkg.
module bsthc_offset (
	input  logic signed [10:0] pos,
	input  logic signed [11:0] center,
	input  logic [15:0]        gain,
	output logic signed [15:0] offset
);
	import bsthc_pkg::*;

	logic signed [11:0] neg_diff;
	logic signed [16:0] gain_s;
	logic signed [28:0] prod;
	logic signed [28:0] rnd;

	always_comb begin
		neg_diff = center - {pos[10], pos};
		gain_s   = {1'b0, gain};
		prod     = 29'(neg_diff) * 29'(gain_s);
		rnd      = prod + ROUND_HALF;
		offset   = sat16(rnd[28:8]);
	end

endmodule

@@ rtl/bsthc_scan.sv @@
// One step of the three-phase pan/tilt search scan with limit clamping.
// Uses bsthc_pkg.
module bsthc_scan (
	input  bsthc_pkg::phase_t       phase,
	input  logic signed [12:0]      head_pan,
	input  logic signed [12:0]      head_tilt,
	input  bsthc_pkg::scan_cfg_t    cfg,
	output bsthc_pkg::scan_res_t    res
);
	import bsthc_pkg::*;

	logic signed [15:0] lim, nlim, top, bot, pan, tilt;
	logic signed [15:0] p, t;
	phase_t             nxt;

	always_comb begin
		lim  = {4'b0, cfg.pan_limit};
		nlim = -lim;
		top  = 16'(cfg.tilt_top);
		bot  = 16'(cfg.tilt_bottom);
		pan  = 16'(head_pan);
		tilt = 16'(head_tilt);
		nxt  = phase;
		p    = pan + PAN_STEP;
		t    = tilt;
		case (phase)
			PH_SWEEP_DOWN: begin
				t = (tilt == top) ? top : bot;
				p = pan - PAN_STEP;
				if (p < nlim) begin
					p   = nlim;
					nxt = PH_SWEEP_TILT;
				end
			end
			PH_SWEEP_TILT: begin
				if (tilt == top) begin
					t = tilt - TILT_STEP;
					if (p > lim || t < bot) begin
						p   = lim;
						t   = bot;
						nxt = PH_SWEEP_DOWN;
					end
				end else begin
					t = tilt + TILT_STEP;
					if (p > lim || t > top) begin
						p   = lim;
						t   = top;
						nxt = PH_SWEEP_DOWN;
					end
				end
			end
			default: begin
				t = ((top - tilt) > (tilt - bot)) ? bot : top;
				if (p > lim) begin
					p   = lim;
					nxt = PH_SWEEP_DOWN;
				end
			end
		endcase
		res.target_pan  = sat13(p);
		res.target_tilt = sat13(t);
		res.next_phase  = nxt;
	end

endmodule

@@ rtl/ball_search_and_track_head_control_top.sv @@
// Ball search and track head control: each accepted input passes through
// the input register, then the result register.
// Throughput 1 item per cycle unless m_tready stalls; the loss counters
// and scan phase close their update loop within the single compute stage.
// Reset (arst_n low): clears valid flags, counters and scan phase, and
// loads the configuration registers with their default values.
module ball_search_and_track_head_control_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// ball_x[10:0], ball_y[21:11], head_pan[34:22], head_tilt[47:35]
	input  logic [bsthc_pkg::IN_W-1:0]         s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// head_action[1:0], target_pan[14:2], target_tilt[27:15],
	// offset_x[43:28], offset_y[59:44], status[61:60], zero[63:62]
	output logic [bsthc_pkg::OUT_W-1:0]        m_tdata,
	input  logic                               cfg_we,
	input  logic [bsthc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bsthc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bsthc_pkg::*;

	logic               track_only_q;
	logic [11:0]        pan_limit_q;
	logic [11:0]        tilt_top_q;
	logic [11:0]        tilt_bottom_q;
	logic [7:0]         patience_q;
	logic [7:0]         give_up_q;
	logic [15:0]        h_gain_q;
	logic [15:0]        v_gain_q;

	phase_t             phase_q;
	logic [7:0]         no_ball_cnt_q;
	logic [7:0]         lost_cnt_q;

	logic               valid_s1;
	logic [IN_W-1:0]    data_s1;
	logic               m_valid_q;
	logic [OUT_W-1:0]   m_data_q;

	logic               advance;
	logic signed [10:0] ball_x, ball_y;
	logic signed [12:0] head_pan, head_tilt;
	logic               found;
	logic signed [11:0] center_y;
	logic signed [15:0] ox_calc, oy_calc;
	scan_cfg_t          scan_cfg;
	scan_res_t          scan_res;

	action_t            action;
	status_t            status;
	logic signed [12:0] tp, tt;
	logic signed [15:0] ox, oy;
	phase_t             phase_nxt;
	logic [7:0]         no_ball_nxt, lost_nxt;

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign ball_x    = data_s1[10:0];
	assign ball_y    = data_s1[21:11];
	assign head_pan  = data_s1[34:22];
	assign head_tilt = data_s1[47:35];
	assign found     = !ball_x[10] && !ball_y[10];
	assign center_y  = track_only_q ? CENTER_Y_TRACK : CENTER_Y_SEARCH;

	assign scan_cfg.pan_limit   = pan_limit_q;
	assign scan_cfg.tilt_top    = tilt_top_q;
	assign scan_cfg.tilt_bottom = tilt_bottom_q;

	bsthc_offset u_off_x (
		.pos    (ball_x),
		.center (CENTER_X),
		.gain   (h_gain_q),
		.offset (ox_calc)
	);

	bsthc_offset u_off_y (
		.pos    (ball_y),
		.center (center_y),
		.gain   (v_gain_q),
		.offset (oy_calc)
	);

	bsthc_scan u_scan (
		.phase     (phase_q),
		.head_pan  (head_pan),
		.head_tilt (head_tilt),
		.cfg       (scan_cfg),
		.res       (scan_res)
	);

	always_comb begin
		action      = ACT_TRACK;
		status      = ST_FOUND;
		tp          = '0;
		tt          = '0;
		ox          = ox_calc;
		oy          = oy_calc;
		phase_nxt   = phase_q;
		no_ball_nxt = '0;
		lost_nxt    = '0;
		if (!found) begin
			ox          = LOST_OFFSET;
			oy          = LOST_OFFSET;
			no_ball_nxt = no_ball_cnt_q;
			if (no_ball_cnt_q < patience_q) begin
				action      = ACT_HOLD;
				no_ball_nxt = no_ball_cnt_q + 8'd1;
			end else if (track_only_q) begin
				action = ACT_INIT;
			end else begin
				action    = ACT_SCAN;
				tp        = scan_res.target_pan;
				tt        = scan_res.target_tilt;
				phase_nxt = scan_res.next_phase;
			end
			lost_nxt = lost_cnt_q;
			if (lost_cnt_q > give_up_q) begin
				status = ST_GIVEN_UP;
			end else begin
				status = ST_LOST;
				if (lost_cnt_q != COUNT_MAX)
					lost_nxt = lost_cnt_q + 8'd1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_only_q  <= RST_TRACK_ONLY;
			pan_limit_q   <= RST_PAN_LIMIT;
			tilt_top_q    <= RST_TILT_TOP;
			tilt_bottom_q <= RST_TILT_BOTTOM;
			patience_q    <= RST_PATIENCE;
			give_up_q     <= RST_GIVE_UP;
			h_gain_q      <= RST_H_GAIN;
			v_gain_q      <= RST_V_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_TRACK_ONLY:  track_only_q  <= cfg_data[0];
				REG_PAN_LIMIT:   pan_limit_q   <= cfg_data[11:0];
				REG_TILT_TOP:    tilt_top_q    <= cfg_data[11:0];
				REG_TILT_BOTTOM: tilt_bottom_q <= cfg_data[11:0];
				REG_PATIENCE:    patience_q    <= cfg_data[7:0];
				REG_GIVE_UP:     give_up_q     <= cfg_data[7:0];
				REG_H_GAIN:      h_gain_q      <= cfg_data;
				REG_V_GAIN:      v_gain_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			data_s1 <= s_tdata;
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q     <= 1'b0;
			phase_q       <= PH_SWEEP_UP;
			no_ball_cnt_q <= '0;
			lost_cnt_q    <= '0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q       <= phase_nxt;
				no_ball_cnt_q <= no_ball_nxt;
				lost_cnt_q    <= lost_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			m_data_q <= {2'b00, status, oy, ox, tt, tp, action};
	end

endmodule

@@ rtl/bsthc_checker.sv @@
// Port-level checks for ball_search_and_track_head_control_top, bound in
// below. Uses bsthc_pkg and the assertion macro header.
`include "ball_search_and_track_head_control_top_defines.svh"

module bsthc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [bsthc_pkg::OUT_W-1:0]  m_tdata
);
	import bsthc_pkg::*;

	logic [1:0]  act;
	logic [12:0] tp, tt;
	logic [15:0] ox, oy;
	logic [1:0]  st;

	assign act = m_tdata[1:0];
	assign tp  = m_tdata[14:2];
	assign tt  = m_tdata[27:15];
	assign ox  = m_tdata[43:28];
	assign oy  = m_tdata[59:44];
	assign st  = m_tdata[61:60];

	`BSTHC_ASSERT(a_found_tracks, !m_tvalid || ((st == ST_FOUND) == (act == ACT_TRACK)))
	`BSTHC_ASSERT(a_target_only_on_scan, !m_tvalid || act == ACT_SCAN || (tp == '0 && tt == '0))
	`BSTHC_ASSERT(a_lost_offset, !m_tvalid || act == ACT_TRACK || (ox == LOST_OFFSET && oy == LOST_OFFSET))
	`BSTHC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind ball_search_and_track_head_control_top bsthc_checker u_bsthc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
